// ===== rtl/vts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the volume trilinear sampler.
// Depends on nothing; every other file imports it.
package vts_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int MAX_DIM     = 64;
    localparam int IDX_W       = 6;
    localparam int EXT_W       = 7;
    localparam int VAL_W       = 16;
    localparam int WGT_W       = FRAC_BITS + 1;
    localparam int BANK_AW     = 3 * (IDX_W - 1);
    localparam int BANK_DEPTH  = 1 << BANK_AW;
    localparam int NUM_BANKS   = 8;
    localparam int ACC_W       = VAL_W + 3 * FRAC_BITS + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int OUT_DEPTH   = 16;
    localparam int OUT_AW      = 4;

    localparam logic [WGT_W-1:0] ONE_WGT = WGT_W'(1 << FRAC_BITS);

    typedef enum logic [1:0] {
        OP_WRITE     = 2'd0,
        OP_NEAREST   = 2'd1,
        OP_TRILINEAR = 2'd2,
        OP_NONE      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_EXTENT_X = 2'd0,
        CFG_EXTENT_Y = 2'd1,
        CFG_EXTENT_Z = 2'd2,
        CFG_OUTSIDE  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic                 is_write;
        logic                 outside;
        logic [IDX_W-1:0]     ix;
        logic [IDX_W-1:0]     iy;
        logic [IDX_W-1:0]     iz;
        logic [FRAC_BITS-1:0] fx;
        logic [FRAC_BITS-1:0] fy;
        logic [FRAC_BITS-1:0] fz;
        logic [VAL_W-1:0]     value;
    } cmd_t;

    typedef struct packed {
        logic                 outside;
        logic [IDX_W-1:0]     idx;
        logic [FRAC_BITS-1:0] frac;
    } axis_t;

    typedef struct packed {
        logic             valid;
        logic             outside;
        logic [VAL_W-1:0] value;
    } tag_t;

endpackage

// ===== rtl/vts_front.sv =====
`timescale 1ns / 1ps
// Front end: configuration registers and classification of accepted items.
// Depends on vts_pkg; feeds vts_queue.
module vts_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic [1:0]                   cfg_index,
    input  logic [15:0]                  cfg_data,
    input  logic                         push,
    input  logic                         q_full,
    input  logic [1:0]                   opcode,
    input  logic signed [15:0]           point_x,
    input  logic signed [15:0]           point_y,
    input  logic signed [15:0]           point_z,
    input  logic [vts_pkg::IDX_W-1:0]    voxel_x,
    input  logic [vts_pkg::IDX_W-1:0]    voxel_y,
    input  logic [vts_pkg::IDX_W-1:0]    voxel_z,
    input  logic signed [15:0]           voxel_value,
    output logic                         q_push,
    output vts_pkg::cmd_t                q_data
);
    import vts_pkg::*;

    logic [EXT_W-1:0] ext_x_reg, ext_y_reg, ext_z_reg;
    logic [VAL_W-1:0] outside_reg;
    axis_t            ax, ay, az;
    logic             nearest;

    function automatic logic [EXT_W-1:0] eff_ext(input logic [EXT_W-1:0] e);
        logic [EXT_W-1:0] r;
        r = e;
        if (e == '0)
            r = EXT_W'(1);
        else if (e > EXT_W'(MAX_DIM))
            r = EXT_W'(MAX_DIM);
        return r;
    endfunction

    function automatic axis_t axis_calc(input logic [15:0] p, input logic [EXT_W-1:0] e,
                                        input logic near);
        logic signed [17:0] ps;
        logic signed [17:0] lim;
        logic signed [17:0] hi;
        logic signed [17:0] rnd;
        axis_t              a;
        ps  = $signed({{2{p[15]}}, p});
        lim = $signed({3'b000, e, 8'h00}) - 18'sd128;
        hi  = $signed({3'b000, e - EXT_W'(1), 8'h00});
        rnd = ps + 18'sd128;
        a.outside = (ps < -18'sd128) || (ps >= lim);
        a.idx     = '0;
        a.frac    = '0;
        if (near) begin
            a.idx = rnd[13:8];
        end
        else if (!p[15]) begin
            a.idx  = p[13:8];
            a.frac = (ps > hi) ? '0 : p[7:0];
        end
        return a;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_x_reg   <= EXT_W'(MAX_DIM);
            ext_y_reg   <= EXT_W'(MAX_DIM);
            ext_z_reg   <= EXT_W'(MAX_DIM);
            outside_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_EXTENT_X: ext_x_reg   <= cfg_data[EXT_W-1:0];
                CFG_EXTENT_Y: ext_y_reg   <= cfg_data[EXT_W-1:0];
                CFG_EXTENT_Z: ext_z_reg   <= cfg_data[EXT_W-1:0];
                CFG_OUTSIDE:  outside_reg <= cfg_data;
                default:      outside_reg <= outside_reg;
            endcase
        end
    end

    assign nearest = (op_t'(opcode) == OP_NEAREST);
    assign ax = axis_calc(point_x, eff_ext(ext_x_reg), nearest);
    assign ay = axis_calc(point_y, eff_ext(ext_y_reg), nearest);
    assign az = axis_calc(point_z, eff_ext(ext_z_reg), nearest);

    always_comb
    begin
        q_push = push && !q_full && (op_t'(opcode) != OP_NONE);
        q_data.is_write = (op_t'(opcode) == OP_WRITE);
        q_data.outside  = 1'b0;
        q_data.ix       = voxel_x;
        q_data.iy       = voxel_y;
        q_data.iz       = voxel_z;
        q_data.fx       = '0;
        q_data.fy       = '0;
        q_data.fz       = '0;
        q_data.value    = voxel_value;
        if (op_t'(opcode) != OP_WRITE)
        begin
            q_data.outside = ax.outside || ay.outside || az.outside;
            q_data.ix      = ax.idx;
            q_data.iy      = ay.idx;
            q_data.iz      = az.idx;
            q_data.fx      = ax.frac;
            q_data.fy      = ay.frac;
            q_data.fz      = az.frac;
            q_data.value   = outside_reg;
        end
    end

endmodule

// ===== rtl/vts_queue.sv =====
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Depends on vts_pkg for the command type and depth.
module vts_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  vts_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output vts_pkg::cmd_t rd_data,
    output logic          empty
);
    import vts_pkg::*;

    cmd_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wptr_reg, rptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign full    = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wptr_reg <= wptr_reg + 1'b1;
            if (rd_en)
                rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_reg + (QUEUE_AW+1)'(wr_en) - (QUEUE_AW+1)'(rd_en);
        end
    end

endmodule

// ===== rtl/vts_back.sv =====
`timescale 1ns / 1ps
// Back end: eight parity-banked voxel memories, weight and product pipeline,
// adder tree, rounding and the result queue. Depends on vts_pkg.
module vts_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  vts_pkg::cmd_t         q_data,
    output logic                  q_pop,
    output logic                  empty,
    input  logic                  pop,
    output logic signed [15:0]    sample_value,
    output logic                  was_outside
);
    import vts_pkg::*;

    localparam int WXY_W = 2 * WGT_W;
    localparam int W3_W  = 3 * FRAC_BITS + 1;

    logic               issue, issue_rd, issue_wr;
    logic [OUT_AW:0]    reserved_reg;
    tag_t               tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg, tag6_reg;
    logic [VAL_W-1:0]   rd_reg   [NUM_BANKS];
    logic [WXY_W-1:0]   wxy_reg  [NUM_BANKS];
    logic [WGT_W-1:0]   wz_reg   [NUM_BANKS];
    logic [W3_W-1:0]    w3_reg   [NUM_BANKS];
    logic [VAL_W-1:0]   d2_reg   [NUM_BANKS];
    logic [ACC_W-1:0]   prod_reg [NUM_BANKS];
    logic [ACC_W-1:0]   sum4_reg [4];
    logic [ACC_W-1:0]   sum2_reg [2];
    logic [ACC_W-1:0]   sum1_reg;
    logic [ACC_W-1:0]   rounded;
    logic [VAL_W-1:0]   result;
    tag_t               out_reg [OUT_DEPTH];
    logic [OUT_AW-1:0]  owptr_reg, orptr_reg;
    logic [OUT_AW:0]    ocount_reg;
    logic               out_pop;

    assign issue    = !q_empty && (q_data.is_write ||
                      (reserved_reg < (OUT_AW+1)'(OUT_DEPTH)));
    assign q_pop    = issue;
    assign issue_wr = issue && q_data.is_write;
    assign issue_rd = issue && !q_data.is_write;
    assign out_pop  = pop && !empty;

    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        localparam logic [2:0] PAR = 3'(b);
        logic [VAL_W-1:0]   mem [BANK_DEPTH];
        logic [IDX_W:0]     cx, cy, cz;
        logic [WGT_W-1:0]   wx, wy, wz;
        logic [BANK_AW-1:0] addr;
        logic               we;

        always_comb
        begin
            cx = {1'b0, q_data.ix} + (IDX_W+1)'(q_data.ix[0] != PAR[0]);
            cy = {1'b0, q_data.iy} + (IDX_W+1)'(q_data.iy[0] != PAR[1]);
            cz = {1'b0, q_data.iz} + (IDX_W+1)'(q_data.iz[0] != PAR[2]);
            wx = (q_data.ix[0] == PAR[0]) ? ONE_WGT - WGT_W'(q_data.fx) : WGT_W'(q_data.fx);
            wy = (q_data.iy[0] == PAR[1]) ? ONE_WGT - WGT_W'(q_data.fy) : WGT_W'(q_data.fy);
            wz = (q_data.iz[0] == PAR[2]) ? ONE_WGT - WGT_W'(q_data.fz) : WGT_W'(q_data.fz);
            we = issue_wr && (q_data.ix[0] == PAR[0]) && (q_data.iy[0] == PAR[1])
                 && (q_data.iz[0] == PAR[2]);
            if (q_data.is_write)
                addr = {q_data.iz[IDX_W-1:1], q_data.iy[IDX_W-1:1], q_data.ix[IDX_W-1:1]};
            else
                addr = {cz[IDX_W-1:1], cy[IDX_W-1:1], cx[IDX_W-1:1]};
        end

        always_ff @(posedge clk)
        begin
            if (we)
                mem[addr] <= q_data.value;
            if (issue_rd)
                rd_reg[b] <= mem[addr];
            wxy_reg[b]  <= wx * wy;
            wz_reg[b]   <= wz;
            w3_reg[b]   <= W3_W'(wxy_reg[b] * wz_reg[b]);
            d2_reg[b]   <= rd_reg[b] ^ 16'h8000;
            // A neighbour with zero weight may never have been written.
            prod_reg[b] <= (w3_reg[b] == '0) ? '0 : ACC_W'(d2_reg[b] * w3_reg[b]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
            sum4_reg[i] <= prod_reg[2*i] + prod_reg[2*i+1];
        for (int i = 0; i < 2; i++)
            sum2_reg[i] <= sum4_reg[2*i] + sum4_reg[2*i+1];
        sum1_reg <= sum2_reg[0] + sum2_reg[1];
    end

    always_comb
    begin
        rounded = (sum1_reg + ACC_W'(1 << (3*FRAC_BITS - 1))) >> (3*FRAC_BITS);
        if (rounded > ACC_W'(16'hFFFF))
            result = 16'h7FFF;
        else
            result = rounded[VAL_W-1:0] ^ 16'h8000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
            tag5_reg <= '0;
            tag6_reg <= '0;
        end
        else
        begin
            tag1_reg <= '{valid: issue_rd, outside: q_data.outside, value: q_data.value};
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
            tag5_reg <= tag4_reg;
            tag6_reg <= tag5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag6_reg.valid)
        begin
            out_reg[owptr_reg].valid   <= 1'b1;
            out_reg[owptr_reg].outside <= tag6_reg.outside;
            out_reg[owptr_reg].value   <= tag6_reg.outside ? tag6_reg.value : result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owptr_reg    <= '0;
            orptr_reg    <= '0;
            ocount_reg   <= '0;
            reserved_reg <= '0;
        end
        else
        begin
            if (tag6_reg.valid)
                owptr_reg <= owptr_reg + 1'b1;
            if (out_pop)
                orptr_reg <= orptr_reg + 1'b1;
            ocount_reg   <= ocount_reg + (OUT_AW+1)'(tag6_reg.valid) - (OUT_AW+1)'(out_pop);
            reserved_reg <= reserved_reg + (OUT_AW+1)'(issue_rd) - (OUT_AW+1)'(out_pop);
        end
    end

    assign empty        = (ocount_reg == '0);
    assign sample_value = out_reg[orptr_reg].value;
    assign was_outside  = out_reg[orptr_reg].outside;

    a_reserved_bound: assert property (@(posedge clk) disable iff (!rst_n)
        reserved_reg <= (OUT_AW+1)'(OUT_DEPTH))
        else $error("result reservations exceed the result queue");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        tag6_reg.valid |-> ocount_reg < (OUT_AW+1)'(OUT_DEPTH))
        else $error("result queue written while full");

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        ocount_reg <= reserved_reg)
        else $error("queued results not covered by reservations");

    a_pipe_track: assert property (@(posedge clk) disable iff (!rst_n)
        issue_rd |=> ##5 tag6_reg.valid)
        else $error("sample lost in the pipeline");

endmodule

// ===== rtl/volume_trilinear_sampler.sv =====
`timescale 1ns / 1ps
// Top level of the volume trilinear sampler: front end, command queue, back end.
// Depends on vts_pkg, vts_front, vts_queue and vts_back.
//
// The sampler holds a 64x64x64 volume of 16-bit voxels in eight memories banked
// by coordinate parity, so all eight trilinear neighbours are read in the same cycle.
// It takes one item per cycle: a write beat updates one voxel, a sample beat gives
// one result once it has passed the bank read, sign-offset, product and adder-tree registers,
// and the result queue of sixteen entries keeps that rate while
// the consumer pops every cycle. Samples stop leaving the command queue only while
// sixteen results are in flight or unread, and the input then stalls once four
// commands wait. Writes and samples take effect in the order they are pushed.
// Configuration writes are always ready and should be made only while the block is idle.
module volume_trilinear_sampler
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [15:0]                  cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic [1:0]                   opcode,
    input  logic signed [15:0]           point_x,
    input  logic signed [15:0]           point_y,
    input  logic signed [15:0]           point_z,
    input  logic [vts_pkg::IDX_W-1:0]    voxel_x,
    input  logic [vts_pkg::IDX_W-1:0]    voxel_y,
    input  logic [vts_pkg::IDX_W-1:0]    voxel_z,
    input  logic signed [15:0]           voxel_value,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [15:0]           sample_value,
    output logic                         was_outside
);
    import vts_pkg::*;

    logic q_push, q_full, q_pop, q_empty;
    cmd_t q_wdata, q_rdata;

    assign cfg_ready = 1'b1;
    assign full      = q_full;

    vts_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .q_full      (q_full),
        .opcode      (opcode),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .voxel_x     (voxel_x),
        .voxel_y     (voxel_y),
        .voxel_z     (voxel_z),
        .voxel_value (voxel_value),
        .q_push      (q_push),
        .q_data      (q_wdata)
    );

    vts_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    vts_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (q_rdata),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .sample_value (sample_value),
        .was_outside  (was_outside)
    );

endmodule
